[src/lga_pkg.sv]
// ----------------------------------------------------------------------------
// lga_pkg: shared definitions for the landing guidance accelerator
// widths, register indexes, status codes and register reset values
// ----------------------------------------------------------------------------
package lga_pkg;

    localparam int FIX_W     = 32;   // signed q16.16 vector components
    localparam int TGO_W     = 31;   // unsigned q15.16 time-to-go
    localparam int ACC_W     = 31;   // unsigned q15.16 acceleration bound
    localparam int DEN_W     = 31;   // divisor width of the divider pipes
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int Q_SHIFT   = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_Z    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TGO_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NORM_ZERO = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT       = 2'd3;

    // register reset values
    localparam logic                    MODE_RST      = 1'b1;
    localparam logic [ACC_W-1:0]        MAX_ACCEL_RST = 31'd1310720;
    localparam logic signed [FIX_W-1:0] GRAV_X_RST    = 32'sd0;
    localparam logic signed [FIX_W-1:0] GRAV_Y_RST    = 32'sd0;
    localparam logic signed [FIX_W-1:0] GRAV_Z_RST    = -32'sd642908;

endpackage

[src/lga_div.sv]
// ----------------------------------------------------------------------------
// lga_div: pipelined unsigned restoring divider
// one quotient bit per stage, side data and valid travel with each item
// ----------------------------------------------------------------------------
module lga_div #(
    parameter int NUM_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [NUM_W-1:0]          in_num,
    input  logic [lga_pkg::DEN_W-1:0] in_den,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [NUM_W-1:0]          out_quo,
    output logic [SIDE_W-1:0]         out_side
);
    import lga_pkg::*;

    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic              vld_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              take;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  nq_next;

        if (k == 0) begin : g_first
            assign nq_in   = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_chain
            assign nq_in   = nq_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // partial remainder picks up the next dividend bit
        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign take     = (trial >= {1'b0, den_in});
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

[src/landing_guidance_accel.sv]
// ----------------------------------------------------------------------------
// landing_guidance_accel: commanded acceleration for a soft landing
// lq law (6r+4tv)/t^2 or bounded law |z|-normalised, plus gravity, saturated
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  --------------------------------
//  s_        in         s_valid / s_ready    pos xyz, vel xyz, time_to_go
//  m_        out        m_valid / m_ready    accel xyz, status
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one transfer per cycle while no result is held at the output; the
//  result path runs through the two bit-per-stage dividers (50 and 64
//  stages) in series
//  reset clears the valid bits and loads the register defaults; no sweep
//  a result held at the output freezes the whole pipe in place, so the
//  input takes a transfer whenever the output is empty or being taken
//
module landing_guidance_accel (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_pos_x,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_pos_y,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_pos_z,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_vel_x,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_vel_y,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_vel_z,
    input  logic [lga_pkg::TGO_W-1:0]         s_time_to_go,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lga_pkg::FIX_W-1:0]  m_accel_x,
    output logic signed [lga_pkg::FIX_W-1:0]  m_accel_y,
    output logic signed [lga_pkg::FIX_W-1:0]  m_accel_z,
    output logic [lga_pkg::STAT_W-1:0]        m_status,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lga_pkg::FIX_W-1:0]         cfg_data
);
    import lga_pkg::*;

    // datapath widths
    localparam int R6_W       = 35;  // 6r signed
    localparam int R6M_W      = 34;  // |6r|
    localparam int DIV1_W     = R6M_W + Q_SHIFT;
    localparam int SIDE1_W    = 1 + FIX_W + TGO_W;
    localparam int TV_W       = 63;  // t*v signed
    localparam int TVD_W      = 47;  // t*v/2^16 signed
    localparam int R3_W       = 34;  // 3r signed
    localparam int Z_W        = 49;  // z signed
    localparam int NORM_W     = 48;  // |z|
    localparam int NORM_STEPS = 6;
    localparam int ZS_W       = 30;  // normalised |z|
    localparam int SQ_W       = 2 * ZS_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int W_W        = 52;  // q + 4v signed
    localparam int WM_W       = 48;  // clamped |w|
    localparam int DIV2_W     = WM_W + Q_SHIFT;
    localparam int PROD_W     = ACC_W + ZS_W;
    localparam int AM_W       = 33;
    localparam int A_W        = AM_W + 1;
    localparam int S_W        = A_W + 1;

    // both laws arrive at the middle stages in step
    localparam int LQ_DEPTH  = 1 + DIV1_W;
    localparam int BND_DEPTH = 4 + NORM_STEPS + 2 + ROOT_STEPS;
    localparam int PAD       = LQ_DEPTH - BND_DEPTH;

    localparam logic [W_W-1:0]    W_LIMIT = W_W'(1) << 47;
    localparam logic [DIV2_W-1:0] A_LIMIT = DIV2_W'(1) << 32;

    typedef struct packed {
        logic                     zero;
        logic [2:0]               neg;
        logic [2:0][ZS_W-1:0]     zs;
    } bside_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                    mode_reg;
    logic [ACC_W-1:0]        max_accel_reg;
    logic signed [FIX_W-1:0] grav_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RST;
            max_accel_reg <= MAX_ACCEL_RST;
            grav_reg[0]   <= GRAV_X_RST;
            grav_reg[1]   <= GRAV_Y_RST;
            grav_reg[2]   <= GRAV_Z_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_MAX_ACCEL: max_accel_reg <= cfg_data[ACC_W-1:0];
                REG_GRAV_X:    grav_reg[0]   <= $signed(cfg_data);
                REG_GRAV_Y:    grav_reg[1]   <= $signed(cfg_data);
                REG_GRAV_Z:    grav_reg[2]   <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipe enable: everything moves unless a result is held at the output
    // ------------------------------------------------------------------
    logic out_vld_reg;
    logic en;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // stage 0: input capture
    // ------------------------------------------------------------------
    logic                    vld0_reg;
    logic signed [FIX_W-1:0] pos_reg [3];
    logic signed [FIX_W-1:0] vel_reg [3];
    logic [TGO_W-1:0]        tgo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            vel_reg[0] <= s_vel_x;
            vel_reg[1] <= s_vel_y;
            vel_reg[2] <= s_vel_z;
            tgo_reg    <= s_time_to_go;
        end
    end

    // ------------------------------------------------------------------
    // lq law, stage 1: |6r| and its sign ahead of the first divider
    // ------------------------------------------------------------------
    logic                    vld1_reg;
    logic [R6M_W-1:0]        r6m_reg  [3];
    logic                    r6n_reg  [3];
    logic signed [FIX_W-1:0] vel1_reg [3];
    logic [TGO_W-1:0]        tgo1_reg;
    logic signed [R6_W-1:0]  r6_next  [3];
    logic [R6M_W-1:0]        r6m_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r6_next[i]  = R6_W'(pos_reg[i]) * $signed(R6_W'(6));
            r6m_next[i] = r6_next[i][R6_W-1] ? R6M_W'(-r6_next[i]) : R6M_W'(r6_next[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6m_reg[i]  <= r6m_next[i];
                r6n_reg[i]  <= r6_next[i][R6_W-1];
                vel1_reg[i] <= vel_reg[i];
            end
            tgo1_reg <= tgo_reg;
        end
    end

    // q = |6r| * 2^16 / t per axis, sign, v and t ride along
    logic                    q1_vld  [3];
    logic [DIV1_W-1:0]       q1_quo  [3];
    logic [SIDE1_W-1:0]      q1_side [3];

    for (genvar i = 0; i < 3; i++) begin : g_div1
        lga_div #(
            .NUM_W  (DIV1_W),
            .SIDE_W (SIDE1_W)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld1_reg),
            .in_num    ({r6m_reg[i], {Q_SHIFT{1'b0}}}),
            .in_den    (tgo1_reg),
            .in_side   ({r6n_reg[i], vel1_reg[i], tgo1_reg}),
            .out_valid (q1_vld[i]),
            .out_quo   (q1_quo[i]),
            .out_side  (q1_side[i])
        );
    end

    // ------------------------------------------------------------------
    // bounded law, runs beside the first divider
    // ------------------------------------------------------------------
    // b1: t*v and 3r
    logic signed [TV_W-1:0]  tv_reg [3];
    logic signed [R3_W-1:0]  r3_reg [3];
    logic signed [63:0]      tv_full [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tv_full[i] = 64'($signed({1'b0, tgo_reg})) * 64'(vel_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                tv_reg[i] <= tv_full[i][TV_W-1:0];
                r3_reg[i] <= R3_W'(pos_reg[i]) * $signed(R3_W'(3));
            end
        end
    end

    // b2: t*v / 2^16 truncated towards zero
    logic signed [TVD_W-1:0] tvd_reg [3];
    logic signed [R3_W-1:0]  r3b_reg [3];
    logic signed [TV_W-1:0]  tv_adj  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tv_adj[i] = tv_reg[i] + (tv_reg[i][TV_W-1] ? TV_W'(65535) : TV_W'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                tvd_reg[i] <= TVD_W'(tv_adj[i] >>> Q_SHIFT);
                r3b_reg[i] <= r3_reg[i];
            end
        end
    end

    // b3: z = 3r + 2(tv), magnitude and sign
    logic [NORM_W-1:0]      zm3_reg  [3];
    logic [2:0]             zneg3_reg;
    logic signed [Z_W-1:0]  z_next   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            z_next[i] = Z_W'(r3b_reg[i]) + (Z_W'(tvd_reg[i]) <<< 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                zm3_reg[i]   <= z_next[i][Z_W-1] ? NORM_W'(-z_next[i]) : NORM_W'(z_next[i]);
                zneg3_reg[i] <= z_next[i][Z_W-1];
            end
        end
    end

    // b4: largest magnitude
    logic [NORM_W-1:0] zm4_reg [3];
    logic [NORM_W-1:0] m4_reg;
    logic [2:0]        zneg4_reg;
    logic              zero4_reg;
    logic [NORM_W-1:0] m01;
    logic [NORM_W-1:0] m_next;

    assign m01    = (zm3_reg[1] > zm3_reg[0]) ? zm3_reg[1] : zm3_reg[0];
    assign m_next = (zm3_reg[2] > m01) ? zm3_reg[2] : m01;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                zm4_reg[i] <= zm3_reg[i];
            end
            m4_reg    <= m_next;
            zneg4_reg <= zneg3_reg;
            zero4_reg <= (m_next == '0);
        end
    end

    // normalise: left shifts of 32..1 until the largest has its top bit set;
    // bits 47:18 then equal the model's right or left shifted magnitudes
    logic [NORM_W-1:0] zn_reg [NORM_STEPS][4];
    logic [3:0]        ns_reg [NORM_STEPS];

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - j);
        logic [NORM_W-1:0] zn_in [4];
        logic [3:0]        ns_in;
        logic              shift_en;

        if (j == 0) begin : g_first
            assign zn_in[0] = zm4_reg[0];
            assign zn_in[1] = zm4_reg[1];
            assign zn_in[2] = zm4_reg[2];
            assign zn_in[3] = m4_reg;
            assign ns_in    = {zero4_reg, zneg4_reg};
        end else begin : g_chain
            assign zn_in[0] = zn_reg[j-1][0];
            assign zn_in[1] = zn_reg[j-1][1];
            assign zn_in[2] = zn_reg[j-1][2];
            assign zn_in[3] = zn_reg[j-1][3];
            assign ns_in    = ns_reg[j-1];
        end

        assign shift_en = (zn_in[3][NORM_W-1 -: SH] == '0);

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 4; k++) begin
                    zn_reg[j][k] <= shift_en ? (zn_in[k] << SH) : zn_in[k];
                end
                ns_reg[j] <= ns_in;
            end
        end
    end

    // squares, then their sum
    logic [SQ_W-1:0]  sq_reg [3];
    bside_t           bs_sq_reg;
    logic [SUM_W-1:0] sum_reg;
    bside_t           bs_sum_reg;
    bside_t           bs_sq_next;

    always_comb begin
        bs_sq_next.zero = ns_reg[NORM_STEPS-1][3];
        bs_sq_next.neg  = ns_reg[NORM_STEPS-1][2:0];
        for (int i = 0; i < 3; i++) begin
            bs_sq_next.zs[i] = zn_reg[NORM_STEPS-1][i][NORM_W-1 -: ZS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQ_W'(bs_sq_next.zs[i]) * SQ_W'(bs_sq_next.zs[i]);
            end
            bs_sq_reg  <= bs_sq_next;
            sum_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            bs_sum_reg <= bs_sq_reg;
        end
    end

    // integer square root, one result bit per stage
    logic [SUM_W-1:0] x_reg     [ROOT_STEPS];
    logic [SUM_W-1:0] res_reg   [ROOT_STEPS];
    bside_t           bs_rt_reg [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic [SUM_W-1:0] x_in;
        logic [SUM_W-1:0] res_in;
        logic [SUM_W-1:0] trial;
        bside_t           bs_in;
        logic             take;

        if (k == 0) begin : g_first
            assign x_in   = sum_reg;
            assign res_in = '0;
            assign bs_in  = bs_sum_reg;
        end else begin : g_chain
            assign x_in   = x_reg[k-1];
            assign res_in = res_reg[k-1];
            assign bs_in  = bs_rt_reg[k-1];
        end

        assign trial = res_in + BIT;
        assign take  = (x_in >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]     <= take ? (x_in - trial) : x_in;
                res_reg[k]   <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
                bs_rt_reg[k] <= bs_in;
            end
        end
    end

    // delay to line up with the lq divider
    bside_t           bs_pad_reg [PAD];
    logic [DEN_W-1:0] n_pad_reg  [PAD];

    for (genvar p = 0; p < PAD; p++) begin : g_pad
        if (p == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    bs_pad_reg[p] <= bs_rt_reg[ROOT_STEPS-1];
                    n_pad_reg[p]  <= res_reg[ROOT_STEPS-1][DEN_W-1:0];
                end
            end
        end else begin : g_chain
            always_ff @(posedge aclk) begin
                if (en) begin
                    bs_pad_reg[p] <= bs_pad_reg[p-1];
                    n_pad_reg[p]  <= n_pad_reg[p-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // middle 1: lq w = q + 4v, bounded max_accel * |z|
    // ------------------------------------------------------------------
    logic                    vld_m_reg;
    logic signed [W_W-1:0]   w_reg    [3];
    logic [PROD_W-1:0]       prod_reg [3];
    logic [TGO_W-1:0]        tgo_m_reg;
    logic [DEN_W-1:0]        n_m_reg;
    bside_t                  bs_m_reg;
    logic signed [W_W-1:0]   qs52     [3];
    logic signed [W_W-1:0]   v4       [3];
    logic signed [W_W-1:0]   w_next   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs52[i]   = W_W'(q1_quo[i]);
            v4[i]     = W_W'($signed(q1_side[i][SIDE1_W-2 -: FIX_W])) <<< 2;
            w_next[i] = q1_side[i][SIDE1_W-1] ? (v4[i] - qs52[i]) : (v4[i] + qs52[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_m_reg <= 1'b0;
        end else if (en) begin
            vld_m_reg <= q1_vld[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                w_reg[i]    <= w_next[i];
                prod_reg[i] <= PROD_W'(max_accel_reg) * PROD_W'(bs_pad_reg[PAD-1].zs[i]);
            end
            tgo_m_reg <= q1_side[0][TGO_W-1:0];
            n_m_reg   <= n_pad_reg[PAD-1];
            bs_m_reg  <= bs_pad_reg[PAD-1];
        end
    end

    // ------------------------------------------------------------------
    // middle 2: clamp |w|, pick the dividend and divisor of the law in use
    // ------------------------------------------------------------------
    logic                vld2_reg;
    logic [DIV2_W-1:0]   num2_reg [3];
    logic                neg2_reg [3];
    logic [DEN_W-1:0]    den2_reg;
    logic                tz2_reg;
    logic                zr2_reg;
    logic [W_W-1:0]      wm       [3];
    logic [WM_W-1:0]     wc       [3];
    logic [DIV2_W-1:0]   num2_next [3];
    logic                neg2_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wm[i] = w_reg[i][W_W-1] ? W_W'(-w_reg[i]) : W_W'(w_reg[i]);
            wc[i] = (wm[i] > W_LIMIT) ? W_LIMIT[WM_W-1:0] : wm[i][WM_W-1:0];
            num2_next[i] = mode_reg ? DIV2_W'(prod_reg[i]) : {wc[i], {Q_SHIFT{1'b0}}};
            neg2_next[i] = mode_reg ? bs_m_reg.neg[i] : w_reg[i][W_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num2_reg[i] <= num2_next[i];
                neg2_reg[i] <= neg2_next[i];
            end
            den2_reg <= mode_reg ? n_m_reg : tgo_m_reg;
            tz2_reg  <= (tgo_m_reg == '0);
            zr2_reg  <= bs_m_reg.zero;
        end
    end

    // second divider, shared by both laws; side is {neg, tgo zero, norm zero}
    logic              q2_vld  [3];
    logic [DIV2_W-1:0] q2_quo  [3];
    logic [2:0]        q2_side [3];

    for (genvar i = 0; i < 3; i++) begin : g_div2
        lga_div #(
            .NUM_W  (DIV2_W),
            .SIDE_W (3)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld2_reg),
            .in_num    (num2_reg[i]),
            .in_den    (den2_reg),
            .in_side   ({neg2_reg[i], tz2_reg, zr2_reg}),
            .out_valid (q2_vld[i]),
            .out_quo   (q2_quo[i]),
            .out_side  (q2_side[i])
        );
    end

    // ------------------------------------------------------------------
    // final 1: clamp magnitude to 2^32 and apply sign
    // ------------------------------------------------------------------
    logic                  vld_f_reg;
    logic signed [A_W-1:0] a_reg [3];
    logic                  tz_f_reg;
    logic                  zr_f_reg;
    logic [AM_W-1:0]       am    [3];
    logic signed [A_W-1:0] a_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            am[i]     = (q2_quo[i] > A_LIMIT) ? A_LIMIT[AM_W-1:0] : q2_quo[i][AM_W-1:0];
            a_next[i] = q2_side[i][2] ? -$signed(A_W'(am[i])) : $signed(A_W'(am[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_f_reg <= 1'b0;
        end else if (en) begin
            vld_f_reg <= q2_vld[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= a_next[i];
            end
            tz_f_reg <= q2_side[0][1];
            zr_f_reg <= q2_side[0][0];
        end
    end

    // ------------------------------------------------------------------
    // final 2: add gravity, saturate, status; this is the output register
    // ------------------------------------------------------------------
    logic signed [FIX_W-1:0] accel_reg [3];
    logic [STAT_W-1:0]       status_reg;
    logic signed [S_W-1:0]   s_sum     [3];
    logic                    sat       [3];
    logic signed [FIX_W-1:0] clamped   [3];
    logic signed [FIX_W-1:0] accel_next [3];
    logic                    bypass;
    logic [STAT_W-1:0]       status_next;

    // zero time-to-go, or a zero vector under the bounded law, gives gravity alone
    assign bypass = tz_f_reg || (mode_reg && zr_f_reg);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_sum[i] = S_W'(a_reg[i]) + S_W'(grav_reg[i]);
            if (s_sum[i] > 35'sd2147483647) begin
                sat[i]     = 1'b1;
                clamped[i] = 32'sh7FFF_FFFF;
            end else if (s_sum[i] < -35'sd2147483648) begin
                sat[i]     = 1'b1;
                clamped[i] = 32'sh8000_0000;
            end else begin
                sat[i]     = 1'b0;
                clamped[i] = s_sum[i][FIX_W-1:0];
            end
            accel_next[i] = bypass ? grav_reg[i] : clamped[i];
        end
        if (tz_f_reg) begin
            status_next = ST_TGO_ZERO;
        end else if (mode_reg && zr_f_reg) begin
            status_next = ST_NORM_ZERO;
        end else if (sat[0] || sat[1] || sat[2]) begin
            status_next = ST_SAT;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                accel_reg[i] <= accel_next[i];
            end
            status_reg <= status_next;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_accel_x = accel_reg[0];
    assign m_accel_y = accel_reg[1];
    assign m_accel_z = accel_reg[2];
    assign m_status  = status_reg;

endmodule

[verif/lga_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lga_checker: guidance command predictor and result checker
// watches the input, result and register channels, predicts each command
// from its own copy of the registers and compares results in order
// ----------------------------------------------------------------------------
module lga_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_pos_x,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_pos_y,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_pos_z,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_vel_x,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_vel_y,
    input  logic signed [lga_pkg::FIX_W-1:0]  s_vel_z,
    input  logic [lga_pkg::TGO_W-1:0]         s_time_to_go,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [lga_pkg::FIX_W-1:0]  m_accel_x,
    input  logic signed [lga_pkg::FIX_W-1:0]  m_accel_y,
    input  logic signed [lga_pkg::FIX_W-1:0]  m_accel_z,
    input  logic [lga_pkg::STAT_W-1:0]        m_status,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [lga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lga_pkg::FIX_W-1:0]         cfg_data,
    output int                                fails,
    output int                                pending,
    output int                                results
);
    import lga_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] ax;
        logic signed [FIX_W-1:0] ay;
        logic signed [FIX_W-1:0] az;
        logic [STAT_W-1:0]       st;
    } command_t;

    command_t                cmd_q[$];
    logic                    mode;
    logic [ACC_W-1:0]        amax;
    logic signed [FIX_W-1:0] grav[3];

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (x >= res + bit_w) begin
                x = x - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic command_t guide(input longint r[3], input longint v[3],
                                       input longint unsigned t);
        command_t        c;
        longint          a[3], z[3], r6, q, w, s, tv;
        longint unsigned zm[3], mx, sum, n, qm, am;
        logic [STAT_W-1:0] st;
        bit              sat;
        st = ST_OK;
        sat = 0;
        if (t == 0) begin
            st = ST_TGO_ZERO;
        end else if (mode == 1'b0) begin
            for (int i = 0; i < 3; i++) begin
                r6 = r[i] * 6;
                qm = (u64_t'(r6 < 0 ? -r6 : r6) << 16) / t;
                q = r6 < 0 ? -longint'(qm) : longint'(qm);
                w = q + 4 * v[i];
                if (w > (longint'(1) <<< 47)) w = longint'(1) <<< 47;
                if (w < -(longint'(1) <<< 47)) w = -(longint'(1) <<< 47);
                am = (u64_t'(w < 0 ? -w : w) << 16) / t;
                if (am > (64'd1 << 32)) am = 64'd1 << 32;
                a[i] = w < 0 ? -longint'(am) : longint'(am);
            end
        end else begin
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                tv = longint'(t) * v[i];
                z[i] = 3 * r[i] + 2 * (tv / 65536);
                zm[i] = u64_t'(z[i] < 0 ? -z[i] : z[i]);
                if (zm[i] > mx) mx = zm[i];
            end
            if (mx == 0) begin
                st = ST_NORM_ZERO;
            end else begin
                // bring the largest magnitude into [2^29, 2^30)
                while (mx >= (64'd1 << 30)) begin
                    mx = mx >> 1;
                    for (int i = 0; i < 3; i++) zm[i] = zm[i] >> 1;
                end
                while (mx < (64'd1 << 29)) begin
                    mx = mx << 1;
                    for (int i = 0; i < 3; i++) zm[i] = zm[i] << 1;
                end
                sum = 0;
                for (int i = 0; i < 3; i++) sum = sum + zm[i] * zm[i];
                n = root_floor(sum);
                for (int i = 0; i < 3; i++) begin
                    am = (u64_t'(amax) * zm[i]) / n;
                    a[i] = z[i] < 0 ? -longint'(am) : longint'(am);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (st != ST_OK) begin
                s = longint'(grav[i]);
            end else begin
                s = a[i] + longint'(grav[i]);
                if (s > 64'sd2147483647) begin
                    s = 64'sd2147483647;
                    sat = 1;
                end
                if (s < -64'sd2147483648) begin
                    s = -64'sd2147483648;
                    sat = 1;
                end
            end
            if (i == 0) c.ax = s[31:0];
            if (i == 1) c.ay = s[31:0];
            if (i == 2) c.az = s[31:0];
        end
        if (st == ST_OK && sat) st = ST_SAT;
        c.st = st;
        return c;
    endfunction

    always @(posedge aclk) begin
        longint   r[3], v[3];
        command_t want, got;
        if (!aresetn) begin
            mode = MODE_RST;
            amax = MAX_ACCEL_RST;
            grav[0] = GRAV_X_RST;
            grav[1] = GRAV_Y_RST;
            grav[2] = GRAV_Z_RST;
            cmd_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:      mode = cfg_data[0];
                    REG_MAX_ACCEL: amax = cfg_data[ACC_W-1:0];
                    REG_GRAV_X:    grav[0] = cfg_data;
                    REG_GRAV_Y:    grav[1] = cfg_data;
                    REG_GRAV_Z:    grav[2] = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                r[0] = s_pos_x; r[1] = s_pos_y; r[2] = s_pos_z;
                v[0] = s_vel_x; v[1] = s_vel_y; v[2] = s_vel_z;
                cmd_q.push_back(guide(r, v, u64_t'(s_time_to_go)));
            end
            if (m_valid && m_ready) begin
                results++;
                got = '{m_accel_x, m_accel_y, m_accel_z, m_status};
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fails++;
                end else begin
                    want = cmd_q.pop_front();
                    if (got.ax !== want.ax) begin
                        $display("%0t: accel_x exp %h got %h", $time, want.ax, got.ax);
                        fails++;
                    end
                    if (got.ay !== want.ay) begin
                        $display("%0t: accel_y exp %h got %h", $time, want.ay, got.ay);
                        fails++;
                    end
                    if (got.az !== want.az) begin
                        $display("%0t: accel_z exp %h got %h", $time, want.az, got.az);
                        fails++;
                    end
                    if (got.st !== want.st) begin
                        $display("%0t: status exp %0d got %0d", $time, want.st, got.st);
                        fails++;
                    end
                end
            end
        end
        pending = cmd_q.size();
    end

endmodule

[verif/landing_guidance_accel_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// landing_guidance_accel_test: top level of the guidance accelerator bench
// drives directed and random state vectors under random stalls through
// several register settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module landing_guidance_accel_test;
    import lga_pkg::*;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [FIX_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [FIX_W-1:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic [TGO_W-1:0]        s_time_to_go = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [FIX_W-1:0] m_accel_x, m_accel_y, m_accel_z;
    logic [STAT_W-1:0]       m_status;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [FIX_W-1:0]        cfg_data = '0;

    int fails, pending, results;
    int sent;
    int settings;
    bit calm;               // no stalls on either side while set

    always #2 aclk = ~aclk;

    landing_guidance_accel u_dut (.*);

    lga_checker u_chk (.*);

    // result side: random hold-off before each transfer
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one input transfer, valid kept high when there is no gap
    task automatic send_vec(input logic signed [FIX_W-1:0] px, py, pz, vx, vy, vz,
                            input logic [TGO_W-1:0] tg);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_pos_x <= px; s_pos_y <= py; s_pos_z <= pz;
        s_vel_x <= vx; s_vel_y <= vy; s_vel_z <= vz;
        s_time_to_go <= tg;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // let every command come back before touching the registers
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // all five registers back to back, valid held across the burst
    task automatic load_regs(input logic md, input logic [ACC_W-1:0] acc,
                             input logic [FIX_W-1:0] gx, gy, gz);
        logic [FIX_W-1:0] val[5];
        val[0] = {31'd0, md};
        val[1] = {1'b0, acc};
        val[2] = gx; val[3] = gy; val[4] = gz;
        for (int i = 0; i < 5; i++) begin
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [FIX_W-1:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h1;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [FIX_W-1:0] near(input int lim);
        return $signed($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // mostly plausible descent states, some full-range noise and corner cases
    task automatic send_random();
        logic signed [FIX_W-1:0] p[3], v[3];
        logic [TGO_W-1:0]        tg;
        int                      kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                0, 1, 2, 3, 4, 5: begin
                    p[i] = near(32'd65536000);
                    v[i] = near(32'd6553600);
                end
                6, 7: begin
                    p[i] = $urandom;
                    v[i] = $urandom;
                end
                8: begin
                    p[i] = '0;
                    v[i] = near(65535);   // t*v below one lsb: zero norm
                end
                default: begin
                    p[i] = edge_val();
                    v[i] = edge_val();
                end
            endcase
        end
        case (kind)
            0, 1, 2, 3, 4, 5: tg = TGO_W'($urandom_range(16384, 60 * 65536));
            6, 7: tg = TGO_W'($urandom);
            8: tg = TGO_W'($urandom_range(0, 1));
            default: tg = ($urandom_range(0, 3) == 0) ? '0 : TGO_W'(edge_val());
        endcase
        send_vec(p[0], p[1], p[2], v[0], v[1], v[2], tg);
    endtask

    // corner vectors, run under each law
    task automatic send_corners();
        send_vec(32'sd65536, 32'sd131072, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, '0);
        send_vec('0, '0, '0, '0, '0, '0, 31'd65536);
        send_vec('0, '0, '0, 32'sd100, -32'sd100, 32'sd5, 31'd1);
        send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
        send_vec(32'h7fff_ffff, 32'h8000_0000, 32'sd1,
                 32'h8000_0000, 32'h7fff_ffff, -32'sd1, 31'd1);
        send_vec(32'sd6553600, -32'sd3276800, 32'sd65536000,
                 -32'sd65536, 32'sd32768, -32'sd1310720, 31'd655360);
        send_vec(32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'h7fff_ffff);
        send_vec(-32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd1);
        send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'd1);
    endtask

    initial begin
        logic [ACC_W-1:0] acc;
        logic [FIX_W-1:0] g[3];
        calm = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: reset registers (bounded law), then lq law
        send_corners();
        drain();
        load_regs(1'b0, MAX_ACCEL_RST, GRAV_X_RST, GRAV_Y_RST, GRAV_Z_RST);
        send_corners();
        drain();

        // random part over a range of register settings
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: acc = '0;
                1: acc = 31'h7fff_ffff;
                2: acc = MAX_ACCEL_RST;
                default: acc = ACC_W'($urandom);
            endcase
            for (int i = 0; i < 3; i++) begin
                case (ph % 4)
                    0: g[i] = 32'h7fff_ffff;
                    1: g[i] = 32'h8000_0000;
                    2: g[i] = near(32'd1310720);
                    default: g[i] = $urandom;
                endcase
            end
            load_regs(ph[0], acc, g[0], g[1], g[2]);
            calm = (ph % 3 == 2);
            repeat (140) send_random();
            drain();
        end
        calm = 1'b0;

        // margin for anything still in flight through the divider chain
        repeat (300) @(posedge aclk);
        $display("covered %0d input transfers and %0d results over %0d register settings",
                 sent, results, settings);
        $display("both laws with zero time-to-go, zero norm and saturating cases");
        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
src/lga_pkg.sv
src/lga_div.sv
src/landing_guidance_accel.sv
verif/lga_checker.sv
verif/landing_guidance_accel_test.sv
